// ===== src/hcbd_pkg.sv =====
package hcbd_pkg;

   localparam int unsigned BODY_TOTAL_BITS = 32;
   localparam logic [BODY_TOTAL_BITS-1:0] MAX_BODY_RESET = 32'd1000000;

   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_TOO_LARGE = 2'd1,
      ERR_SIZE_OVF  = 2'd2
   } err_code_type;

   typedef struct packed {
      logic         body_valid;
      logic [7:0]   body_byte;
      logic         finished;
      err_code_type error_code;
   } rsp_type;

endpackage

// ===== src/hcbd_req_if.sv =====
interface hcbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       new_message;

   modport source (output valid, output data_byte, output new_message, input ready);
   modport sink   (input valid, input data_byte, input new_message, output ready);
endinterface

// ===== src/hcbd_rsp_if.sv =====
interface hcbd_rsp_if;
   logic       valid;
   logic       ready;
   logic       body_valid;
   logic [7:0] body_byte;
   logic       finished;
   logic [1:0] error_code;

   modport source (output valid, output body_valid, output body_byte, output finished,
                   output error_code, input ready);
   modport sink   (input valid, input body_valid, input body_byte, input finished,
                   input error_code, output ready);
endinterface

// ===== src/hcbd_parser.sv =====
module hcbd_parser #(
   parameter int unsigned SIZE_BITS = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    step,
   input  logic [7:0]                              data_byte,
   input  logic                                    new_message,
   input  logic [hcbd_pkg::BODY_TOTAL_BITS-1:0]    max_body,
   output hcbd_pkg::rsp_type                       result
);

   typedef enum logic [1:0] {
      PH_SIZE = 2'd0,
      PH_DATA = 2'd1,
      PH_SKIP = 2'd2,
      PH_DONE = 2'd3
   } phase_type;

   phase_type                              phase_ff, phase_in;
   logic                                   cr_pending_ff, cr_pending_in;
   logic [SIZE_BITS-1:0]                   chunk_size_ff, chunk_size_in;
   logic [SIZE_BITS-1:0]                   chunk_count_ff, chunk_count_in;
   logic [hcbd_pkg::BODY_TOTAL_BITS-1:0]   body_total_ff, body_total_in;
   hcbd_pkg::err_code_type                 error_ff, error_in;

   // state as seen by this byte, after an optional new-message clear
   phase_type                              cur_phase;
   logic                                   cur_cr;
   logic [SIZE_BITS-1:0]                   cur_size;
   logic [SIZE_BITS-1:0]                   cur_count;
   logic [hcbd_pkg::BODY_TOTAL_BITS-1:0]   cur_total;
   hcbd_pkg::err_code_type                 cur_error;

   logic [4:0]                             hex;
   logic [SIZE_BITS:0]                     count_next;
   logic                                   out_valid;

   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c inside {[8'h30:8'h39]}) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c inside {[8'h41:8'h46]}) begin
         r = {1'b1, 4'(c - 8'h37)};
      end else if (c inside {[8'h61:8'h66]}) begin
         r = {1'b1, 4'(c - 8'h57)};
      end
      return r;
   endfunction

   always_comb begin
      cur_phase = new_message ? PH_SIZE : phase_ff;
      cur_cr    = new_message ? 1'b0 : cr_pending_ff;
      cur_size  = new_message ? '0 : chunk_size_ff;
      cur_count = new_message ? '0 : chunk_count_ff;
      cur_total = new_message ? '0 : body_total_ff;
      cur_error = new_message ? hcbd_pkg::ERR_NONE : error_ff;

      hex        = hex_decode(data_byte);
      count_next = {1'b0, cur_count} + {{SIZE_BITS{1'b0}}, 1'b1};

      phase_in       = cur_phase;
      cr_pending_in  = cur_cr;
      chunk_size_in  = cur_size;
      chunk_count_in = cur_count;
      body_total_in  = cur_total;
      error_in       = cur_error;
      out_valid      = 1'b0;

      if (cur_error == hcbd_pkg::ERR_NONE) begin
         case (cur_phase)
            PH_SIZE: begin
               if (data_byte == hcbd_pkg::CH_LF && cur_cr) begin
                  cr_pending_in = 1'b0;
                  if (cur_size == '0) begin
                     phase_in = PH_DONE;
                  end else begin
                     phase_in       = PH_DATA;
                     chunk_count_in = '0;
                  end
               end else begin
                  cr_pending_in = (data_byte == hcbd_pkg::CH_CR);
                  if (hex[4]) begin
                     // another digit would shift set bits out of the size
                     if (|cur_size[SIZE_BITS-1 -: 4]) begin
                        error_in = hcbd_pkg::ERR_SIZE_OVF;
                     end else begin
                        chunk_size_in = {cur_size[SIZE_BITS-5:0], hex[3:0]};
                     end
                  end
               end
            end
            PH_DATA: begin
               if (cur_total >= max_body) begin
                  error_in = hcbd_pkg::ERR_TOO_LARGE;
               end else begin
                  out_valid      = 1'b1;
                  body_total_in  = cur_total
                                 + {{(hcbd_pkg::BODY_TOTAL_BITS-1){1'b0}}, 1'b1};
                  chunk_count_in = count_next[SIZE_BITS-1:0];
                  if (count_next >= {1'b0, cur_size}) begin
                     phase_in      = PH_SKIP;
                     cr_pending_in = 1'b0;
                  end
               end
            end
            PH_SKIP: begin
               if (data_byte == hcbd_pkg::CH_LF && cur_cr) begin
                  cr_pending_in  = 1'b0;
                  phase_in       = PH_SIZE;
                  chunk_size_in  = '0;
                  chunk_count_in = '0;
               end else begin
                  cr_pending_in = (data_byte == hcbd_pkg::CH_CR);
               end
            end
            default: begin
               // finished: hold everything until a new message
            end
         endcase
      end

      result.body_valid = out_valid;
      result.body_byte  = out_valid ? data_byte : 8'd0;
      result.finished   = (phase_in == PH_DONE);
      result.error_code = error_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_SIZE;
         cr_pending_ff  <= 1'b0;
         chunk_size_ff  <= '0;
         chunk_count_ff <= '0;
         body_total_ff  <= '0;
         error_ff       <= hcbd_pkg::ERR_NONE;
      end else if (step) begin
         phase_ff       <= phase_in;
         cr_pending_ff  <= cr_pending_in;
         chunk_size_ff  <= chunk_size_in;
         chunk_count_ff <= chunk_count_in;
         body_total_ff  <= body_total_in;
         error_ff       <= error_in;
      end
   end

   a_data_count_below_size: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> chunk_count_ff < chunk_size_ff)
      else $error("chunk count reached chunk size while still in payload");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      step && !new_message && error_ff != hcbd_pkg::ERR_NONE |=>
      error_ff == $past(error_ff))
      else $error("error cleared without a new message");

   a_no_payload_on_error: assert property (@(posedge clock) disable iff (reset)
      step && result.body_valid |-> result.error_code == hcbd_pkg::ERR_NONE)
      else $error("payload byte passed out together with an error");

   a_no_payload_when_done: assert property (@(posedge clock) disable iff (reset)
      step && result.finished |-> !result.body_valid)
      else $error("payload byte passed out after the last chunk");

endmodule

// ===== src/http_chunked_body_decoder_core.sv =====
// Chunked body decoder: takes one raw body byte per transfer on req_chan and returns
// exactly one result per byte on rsp_chan (payload byte with body_valid, finished, sticky
// error code). Each byte is decoded combinationally against the parser state and lands in
// the result register, so a new byte is taken every clock as long as the result side keeps
// up; throughput is one byte per cycle. Set new_message on the first byte of each body to
// clear all parser state. csr_wr_data is the body size limit, to be written only while no
// bytes are in flight. SIZE_BITS sets the widest chunk length.
module http_chunked_body_decoder_core #(
   parameter int unsigned SIZE_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   hcbd_req_if.sink                              req_chan,
   hcbd_rsp_if.source                            rsp_chan,
   input  logic                                  csr_wr_en,
   input  logic [hcbd_pkg::BODY_TOTAL_BITS-1:0]  csr_wr_data
);

   logic [hcbd_pkg::BODY_TOTAL_BITS-1:0] max_body_ff;
   hcbd_pkg::rsp_type                    rsp_ff;
   logic                                 rsp_valid_ff;
   hcbd_pkg::rsp_type                    result;
   logic                                 accept;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   hcbd_parser #(
      .SIZE_BITS (SIZE_BITS)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (accept),
      .data_byte   (req_chan.data_byte),
      .new_message (req_chan.new_message),
      .max_body    (max_body_ff),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         max_body_ff <= hcbd_pkg::MAX_BODY_RESET;
      end else if (csr_wr_en) begin
         max_body_ff <= csr_wr_data;
      end
   end

   // hold the result until its transfer, refill on each accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.body_valid = rsp_ff.body_valid;
   assign rsp_chan.body_byte  = rsp_ff.body_byte;
   assign rsp_chan.finished   = rsp_ff.finished;
   assign rsp_chan.error_code = rsp_ff.error_code;

endmodule
